@@ src/assert_macros.svh @@
// Assertion macros shared by the tokenizer RTL.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge out of reset.
`define AST_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// When the trigger holds, the consequence must hold in the cycle after.
`define AST_ASSERT_NEXT(label, trig, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cons)) \
		else $error(msg);

`endif

@@ src/ast_pkg.sv @@
// Package for the assembly source tokenizer: word types, token codes,
// character classes, keyword table and token builders. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ast_pkg;

	localparam int KEYWORD_MAX_CHARS = 5;
	localparam int PREFIX_W          = 8 * KEYWORD_MAX_CHARS;
	localparam int KW_COUNT          = 21;

	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

	localparam logic [30:0] NUM_SAT = 31'h7FFF_FFFF;

	localparam logic [3:0] K_INSTR   = 4'd0;
	localparam logic [3:0] K_LABEL   = 4'd1;
	localparam logic [3:0] K_NUMBER  = 4'd2;
	localparam logic [3:0] K_PERIOD  = 4'd3;
	localparam logic [3:0] K_COMMA   = 4'd4;
	localparam logic [3:0] K_AMP     = 4'd5;
	localparam logic [3:0] K_HASH    = 4'd6;
	localparam logic [3:0] K_MINUS   = 4'd7;
	localparam logic [3:0] K_NEWLINE = 4'd8;
	localparam logic [3:0] K_EOF     = 4'd9;
	localparam logic [3:0] K_ILLEGAL = 4'd10;

	localparam logic [2:0] MODE_IDLE    = 3'd0;
	localparam logic [2:0] MODE_WORD    = 3'd1;
	localparam logic [2:0] MODE_NUM     = 3'd2;
	localparam logic [2:0] MODE_DASH    = 3'd3;
	localparam logic [2:0] MODE_COMMENT = 3'd4;

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_COMMA = 8'h2C;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_SEMI  = 8'h3B;
	localparam logic [7:0] CH_ZERO  = 8'h30;

	typedef struct packed {
		logic [7:0] source_byte;
		logic       final_byte;
	} src_t;

	typedef struct packed {
		logic [3:0]  token_kind;
		logic [4:0]  keyword_code;
		logic [30:0] number_value;
		logic [31:0] label_offset;
		logic [15:0] label_length;
		logic [31:0] line_number;
		logic [15:0] column_number;
		logic        stream_done;
	} tok_t;

	typedef struct packed {
		logic [FIFO_CW-1:0] count;
		logic               room;
	} fifo_stat_t;

	function automatic logic is_alpha(input logic [7:0] c);
		return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == 8'h5F;
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	// Keywords packed first byte in the low bits.
	function automatic logic [39:0] kw_text(input int i);
		case (i)
			0:       return 40'h0000_766f6d;
			1:       return 40'h0000_646461;
			2:       return 40'h0000_627573;
			3:       return 40'h0000_766964;
			4:       return 40'h0000_6c756d;
			5:       return 40'h0000_646f6d;
			6:       return 40'h0000_726873;
			7:       return 40'h0000_6c6873;
			8:       return 40'h0000_636e69;
			9:       return 40'h0000_636564;
			10:      return 40'h0000_706d6a;
			11:      return 40'h0000_7a6e6a;
			12:      return 40'h0000_72736a;
			13:      return 40'h0000_007a6a;
			14:      return 40'h0000_00656a;
			15:      return 40'h0000_656e6a;
			16:      return 40'h0000_656c6a;
			17:      return 40'h0000_72676a;
			18:      return 40'h0000_74756f;
			19:      return 40'h7475_706e69;
			20:      return 40'h0000_746572;
			default: return 40'h0;
		endcase
	endfunction

	function automatic logic [15:0] kw_len(input int i);
		case (i)
			13, 14:  return 16'd2;
			19:      return 16'd5;
			default: return 16'd3;
		endcase
	endfunction

	function automatic tok_t make_tok(input logic [3:0] kind, input logic [31:0] line,
		input logic [15:0] col);
		tok_t t;
		t               = '0;
		t.token_kind    = kind;
		t.line_number   = line;
		t.column_number = col;
		t.stream_done   = (kind == K_EOF);
		return t;
	endfunction

	// Token for whatever the mode holds; caller checks that the mode is pending.
	function automatic tok_t flush_tok(input logic [2:0] mode,
		input logic [PREFIX_W-1:0] prefix, input logic [15:0] count,
		input logic [31:0] wbegin, input logic [30:0] sum, input logic [15:0] ncol,
		input logic [31:0] line, input logic [15:0] col);
		tok_t t;
		logic hit;
		t   = make_tok(K_MINUS, line, col);
		hit = 1'b0;
		case (mode)
			MODE_WORD: begin
				t.token_kind   = K_LABEL;
				t.label_offset = wbegin;
				t.label_length = count;
				for (int i = 0; i < KW_COUNT; i++) begin
					if (!hit && count == kw_len(i) && prefix == PREFIX_W'(kw_text(i))) begin
						hit            = 1'b1;
						t.token_kind   = K_INSTR;
						t.keyword_code = 5'(i);
						t.label_offset = '0;
						t.label_length = '0;
					end
				end
			end
			MODE_NUM: begin
				t.token_kind    = K_NUMBER;
				t.number_value  = sum;
				t.column_number = ncol;
			end
			default: begin
				t.token_kind = K_MINUS;
			end
		endcase
		return t;
	endfunction

	function automatic logic is_pending(input logic [2:0] mode);
		return mode == MODE_WORD || mode == MODE_NUM || mode == MODE_DASH;
	endfunction

endpackage

`default_nettype wire

@@ src/assembly_source_tokenizer.sv @@
// Assembly source tokenizer, one source byte per word in, one token per word out.
// A byte is taken in every cycle while the token queue has room for three
// tokens; its tokens (at most three: a pending word, number or minus, the
// byte's own token, and on the final byte a flush plus eof) enter an
// eight-entry queue in the same cycle. Input rate is one byte per cycle, and
// output one token per cycle while tok_ready is high, set by the single read port.
// Depends on ast_pkg, ast_token_fifo and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module assembly_source_tokenizer import ast_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic src_valid,
	output logic      src_ready,
	input  wire src_t src,
	output logic      tok_valid,
	input  wire logic tok_ready,
	output tok_t      tok
);

	logic [2:0]          mode_q, mode_n;
	logic [PREFIX_W-1:0] prefix_q, prefix_n;
	logic [15:0]         wcount_q, wcount_n;
	logic [31:0]         wbegin_q, wbegin_n;
	logic [30:0]         sum_q, sum_n;
	logic [15:0]         ncol_q, ncol_n;
	logic [31:0]         line_q, line_n;
	logic [15:0]         col_q, col_n;
	logic [31:0]         pos_q, pos_n;
	logic                err_q, err_n;

	tok_t       cand [4];
	logic [3:0] cand_v;
	tok_t       slot [3];
	logic [1:0] wr_num;
	logic       take;
	fifo_stat_t fstat;

	logic [7:0]  b;
	logic        consumed;
	logic [34:0] mac;

	assign b         = src.source_byte;
	assign src_ready = fstat.room;
	assign take      = src_valid && src_ready;

	always_comb begin
		mode_n   = mode_q;
		prefix_n = prefix_q;
		wcount_n = wcount_q;
		wbegin_n = wbegin_q;
		sum_n    = sum_q;
		ncol_n   = ncol_q;
		err_n    = err_q;
		consumed = 1'b0;
		cand_v   = '0;
		mac      = {sum_q, 3'b000} + {3'b000, sum_q, 1'b0} + {31'd0, b[3:0] - CH_ZERO[3:0]};

		// every byte advances position once, and the line on LF or else the column (saturating)
		pos_n = pos_q + 32'd1;
		if (b == CH_LF) begin
			line_n = line_q + 32'd1;
			col_n  = '0;
		end else begin
			line_n = line_q;
			col_n  = (col_q == 16'hFFFF) ? col_q : col_q + 16'd1;
		end

		cand[0] = flush_tok(mode_q, prefix_q, wcount_q, wbegin_q, sum_q, ncol_q,
			line_q, col_q);

		case (mode_q)
			MODE_COMMENT: begin
				if (b == CH_LF) mode_n = MODE_IDLE;
				else consumed = 1'b1;
			end
			MODE_DASH: begin
				if (b == CH_DASH) begin
					mode_n   = MODE_COMMENT;
					consumed = 1'b1;
				end else begin
					cand_v[0] = 1'b1;
					mode_n    = MODE_IDLE;
				end
			end
			MODE_WORD: begin
				if (is_alpha(b) || is_digit(b)) begin
					for (int i = 0; i < KEYWORD_MAX_CHARS; i++) begin
						if (wcount_q == 16'(i)) prefix_n[8*i +: 8] = b;
					end
					if (wcount_q != 16'hFFFF) wcount_n = wcount_q + 16'd1;
					consumed = 1'b1;
				end else begin
					cand_v[0] = 1'b1;
					mode_n    = MODE_IDLE;
				end
			end
			MODE_NUM: begin
				if (is_digit(b)) begin
					sum_n    = (mac > 35'(NUM_SAT)) ? NUM_SAT : mac[30:0];
					consumed = 1'b1;
				end else begin
					cand_v[0] = 1'b1;
					mode_n    = MODE_IDLE;
				end
			end
			default: begin
				mode_n = MODE_IDLE;
			end
		endcase

		cand[1] = make_tok(K_NEWLINE, line_n, col_n);
		if (!consumed) begin
			if (b == CH_SPACE || b == CH_TAB || b == CH_CR) begin
				cand_v[1] = 1'b0;
			end else if (b == CH_LF || b == CH_SEMI) begin
				cand_v[1] = 1'b1;
			end else if (b == CH_DOT) begin
				cand_v[1] = 1'b1;
				cand[1].token_kind = K_PERIOD;
			end else if (b == CH_COMMA) begin
				cand_v[1] = 1'b1;
				cand[1].token_kind = K_COMMA;
			end else if (b == CH_AMP) begin
				cand_v[1] = 1'b1;
				cand[1].token_kind = K_AMP;
			end else if (b == CH_HASH) begin
				cand_v[1] = 1'b1;
				cand[1].token_kind = K_HASH;
			end else if (b == CH_DASH) begin
				mode_n = MODE_DASH;
			end else if (is_alpha(b)) begin
				mode_n   = MODE_WORD;
				wbegin_n = pos_q;
				wcount_n = 16'd1;
				prefix_n = PREFIX_W'(b);
			end else if (is_digit(b)) begin
				mode_n = MODE_NUM;
				sum_n  = 31'(b - CH_ZERO);
				ncol_n = col_n;
			end else begin
				err_n     = 1'b1;
				cand_v[1] = 1'b1;
				cand[1].token_kind = K_ILLEGAL;
			end
		end

		cand[2] = flush_tok(mode_n, prefix_n, wcount_n, wbegin_n, sum_n, ncol_n,
			line_n, col_n);
		cand[3] = make_tok(K_EOF, line_n, col_n);
		if (src.final_byte) begin
			cand_v[2] = is_pending(mode_n);
			cand_v[3] = 1'b1;
			// back to reset state for the next source
			mode_n   = MODE_IDLE;
			prefix_n = '0;
			wcount_n = '0;
			wbegin_n = '0;
			sum_n    = '0;
			ncol_n   = '0;
			line_n   = 32'd1;
			col_n    = '0;
			pos_n    = '0;
			err_n    = 1'b0;
		end
	end

	// pack valid candidates into consecutive queue slots
	always_comb begin
		logic [2:0] n;
		n = '0;
		for (int s = 0; s < 3; s++) slot[s] = cand[3];
		for (int i = 0; i < 4; i++) begin
			if (cand_v[i]) begin
				if (n < 3'd3) slot[n[1:0]] = cand[i];
				n = n + 3'd1;
			end
		end
		wr_num = take ? n[1:0] : 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			prefix_q <= '0;
			wcount_q <= '0;
			wbegin_q <= '0;
			sum_q    <= '0;
			ncol_q   <= '0;
			line_q   <= 32'd1;
			col_q    <= '0;
			pos_q    <= '0;
			err_q    <= 1'b0;
		end else if (take) begin
			mode_q   <= mode_n;
			prefix_q <= prefix_n;
			wcount_q <= wcount_n;
			wbegin_q <= wbegin_n;
			sum_q    <= sum_n;
			ncol_q   <= ncol_n;
			line_q   <= line_n;
			col_q    <= col_n;
			pos_q    <= pos_n;
			err_q    <= err_n;
		end
	end

	ast_token_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_num   (wr_num),
		.wr_tok   (slot),
		.rd_tok   (tok),
		.rd_valid (tok_valid),
		.rd_ready (tok_ready),
		.stat     (fstat)
	);

	`AST_ASSERT(a_fifo_bound, fstat.count <= FIFO_CW'(FIFO_DEPTH), "token queue overflow")
	`AST_ASSERT(a_out_valid, tok_valid == (fstat.count != '0), "token valid disagrees with fill")
	`AST_ASSERT_NEXT(a_final_reset, take && src.final_byte, mode_q == MODE_IDLE && line_q == 32'd1 && pos_q == '0 && !err_q, "state not cleared after final byte")
	`AST_ASSERT(a_err_line, !(mode_q == MODE_COMMENT && pos_q == '0), "comment mode at source start")

endmodule

`default_nettype wire

@@ src/ast_token_fifo.sv @@
// Token queue: takes up to three tokens per cycle, hands out one per cycle while rd_ready is high.
// Depends on ast_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ast_token_fifo import ast_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic [1:0] wr_num,
	input  wire tok_t       wr_tok [3],
	output tok_t            rd_tok,
	output logic            rd_valid,
	input  wire logic       rd_ready,
	output fifo_stat_t      stat
);

	tok_t               mem [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wptr_q, rptr_q;
	logic [FIFO_CW-1:0] count_q;
	logic               pop;

	assign rd_valid  = (count_q != '0);
	assign rd_tok    = mem[rptr_q];
	assign pop       = rd_valid && rd_ready;
	assign stat.count = count_q;
	assign stat.room  = (count_q <= FIFO_CW'(FIFO_DEPTH - 3));

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			if (2'(i) < wr_num) begin
				mem[wptr_q + FIFO_AW'(i)] <= wr_tok[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q  <= '0;
			rptr_q  <= '0;
			count_q <= '0;
		end else begin
			wptr_q  <= wptr_q + FIFO_AW'(wr_num);
			rptr_q  <= rptr_q + FIFO_AW'(pop);
			count_q <= count_q + FIFO_CW'(wr_num) - FIFO_CW'(pop);
		end
	end

endmodule

`default_nettype wire
